[rtl/core/fppi_pkg.sv]
// Shared constants and types for the pulse peak and integral block.
package fppi_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int HEADER_BYTES = 32;
  localparam int MAX_SAMPLES  = 1008;
  localparam int MAX_WINDOW   = 64;
  localparam int WINDOW_RESET = 40;

  localparam int POS_W      = 11;
  localparam int CNT_W      = 10;
  localparam int WIN_W      = 7;
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 12;
  localparam int PSUM_W     = 18;
  localparam int SUM_W      = 22;
  localparam int FRAC_W     = 6;
  localparam int PED_W      = PSUM_W + FRAC_W;
  localparam int PROD_W     = CNT_W + PED_W;
  localparam int PEAK_W     = 18;
  localparam int INTEG_W    = 29;
  localparam int CH_W       = 2;
  localparam int MASK_W     = 4;
  localparam int STEP_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES = 2'd0,
    REG_WINDOW  = 2'd1,
    REG_MASK    = 2'd2,
    REG_SPARE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    step;
    logic                    take_low;
    logic                    take_high;
    logic                    in_window;
    logic                    close;
    logic [WIN_W-1:0]        pedn;
    logic [CNT_W-1:0]        count;
    logic [NUM_CHANNELS-1:0] mask;
  } fppi_ctl_t;

  typedef struct packed {
    logic               idle;
    logic               done;
    logic [PEAK_W-1:0]  peak;
    logic [INTEG_W-1:0] integral;
  } fppi_res_t;

endpackage

[rtl/core/fppi_lane.sv]
// One channel lane: sample accumulation, pedestal divider and result arithmetic.
module fppi_lane
  import fppi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  fppi_ctl_t         ctl,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              release_lanes,
  output fppi_res_t         res
);

  typedef enum logic [2:0] {L_IDLE, L_DIV, L_MUL, L_SUB, L_DONE} state_t;

  state_t              st;
  logic [BYTE_W-1:0]   low_hold;
  logic [PSUM_W-1:0]   psum;
  logic [SAMPLE_W-1:0] max_smp;
  logic [SUM_W-1:0]    ssum;

  logic [STEP_W-1:0]   step_cnt;
  logic [PED_W-1:0]    dvd;
  logic [WIN_W-1:0]    rem;
  logic [WIN_W-1:0]    divisor;
  logic [CNT_W-1:0]    count_s;
  logic [SAMPLE_W-1:0] max_s;
  logic [SUM_W-1:0]    sum_s;
  logic [PROD_W-1:0]   prod;
  logic [PEAK_W-1:0]   peak;
  logic [INTEG_W-1:0]  integ;

  logic [SAMPLE_W-1:0] smp;
  logic [PSUM_W-1:0]   psum_next;
  logic [SAMPLE_W-1:0] max_next;
  logic [SUM_W-1:0]    ssum_next;
  logic [WIN_W:0]      trial;
  logic [WIN_W:0]      trial_diff;
  logic                fits;
  logic [PED_W-1:0]    max_ext;
  logic [PED_W-1:0]    peak_diff;

  always_comb begin
    smp       = {byte_in[3:0], low_hold};
    psum_next = psum;
    max_next  = max_smp;
    ssum_next = ssum;
    if (ctl.take_high) begin
      if (ctl.in_window) begin
        psum_next = psum + PSUM_W'(smp);
      end
      if (smp > max_smp) begin
        max_next = smp;
      end
      ssum_next = ssum + SUM_W'(smp);
    end
  end

  assign trial      = {rem, dvd[PED_W-1]};
  assign fits       = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};
  assign max_ext    = PED_W'({max_s, {FRAC_W{1'b0}}});
  assign peak_diff  = max_ext - dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= L_IDLE;
      low_hold <= '0;
      psum     <= '0;
      max_smp  <= '0;
      ssum     <= '0;
    end else begin
      if (ctl.step) begin
        if (ctl.close) begin
          low_hold <= '0;
          psum     <= '0;
          max_smp  <= '0;
          ssum     <= '0;
          dvd      <= {psum_next, {FRAC_W{1'b0}}};
          rem      <= '0;
          divisor  <= ctl.pedn;
          count_s  <= ctl.count;
          max_s    <= max_next;
          sum_s    <= ssum_next;
          step_cnt <= STEP_W'(PED_W - 1);
          st       <= L_DIV;
        end else begin
          if (ctl.take_low) begin
            low_hold <= byte_in;
          end
          psum    <= psum_next;
          max_smp <= max_next;
          ssum    <= ssum_next;
        end
      end
      case (st)
        L_IDLE: begin
        end
        L_DIV: begin
          dvd <= {dvd[PED_W-2:0], fits};
          rem <= fits ? trial_diff[WIN_W-1:0] : trial[WIN_W-1:0];
          step_cnt <= step_cnt - STEP_W'(1);
          if (step_cnt == '0) begin
            st <= L_MUL;
          end
        end
        L_MUL: begin
          prod <= PROD_W'(count_s) * PROD_W'(dvd);
          st   <= L_SUB;
        end
        L_SUB: begin
          peak  <= (max_ext > dvd) ? peak_diff[PEAK_W-1:0] : '0;
          integ <= {1'b0, sum_s, {FRAC_W{1'b0}}} - prod[INTEG_W-1:0];
          st    <= L_DONE;
        end
        L_DONE: begin
          if (release_lanes) begin
            st <= L_IDLE;
          end
        end
        default: begin
          st <= L_IDLE;
        end
      endcase
    end
  end

  assign res.idle     = (st == L_IDLE);
  assign res.done     = (st == L_DONE);
  assign res.peak     = peak;
  assign res.integral = integ;

  assert property (@(posedge clk) disable iff (rst)
    (st == L_DIV && step_cnt == '0) |=> (st == L_MUL))
    else $error("divider left early or late");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.step && ctl.close) |-> (st == L_IDLE))
    else $error("event closed while lane busy");

  assert property (@(posedge clk) disable iff (rst)
    (st == L_MUL) |-> (divisor != '0))
    else $error("zero pedestal divisor");

endmodule

[rtl/core/fppi_merge.sv]
// Merge stage: walks enabled lanes in channel order into the output register.
module fppi_merge
  import fppi_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  fppi_ctl_t               ctl,
  input  fppi_res_t               res [NUM_CHANNELS],
  output logic                    release_lanes,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         channel,
  output logic [PEAK_W-1:0]       peak_q6,
  output logic signed [INTEG_W-1:0] integral_q6,
  output logic                    last
);

  logic [NUM_CHANNELS-1:0] pending;
  logic [NUM_CHANNELS-1:0] sel_hot;
  logic [CH_W-1:0]         sel;
  logic                    all_done;
  logic                    adv;

  always_comb begin
    sel      = '0;
    sel_hot  = '0;
    all_done = 1'b1;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel     = CH_W'(i);
        sel_hot = NUM_CHANNELS'(1) << i;
      end
      if (!res[i].done) begin
        all_done = 1'b0;
      end
    end
  end

  assign adv           = all_done && (pending != '0) && (!out_valid || out_ready);
  assign release_lanes = all_done && (pending == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.step && ctl.close) begin
        pending <= ctl.mask;
      end else if (adv) begin
        pending <= pending & ~sel_hot;
      end
      if (adv) begin
        out_valid   <= 1'b1;
        channel     <= sel;
        peak_q6     <= res[sel].peak;
        integral_q6 <= res[sel].integral;
        last        <= (pending & ~sel_hot) == '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    adv |-> $onehot(sel_hot))
    else $error("no single lane selected");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.step && ctl.close) |-> (pending == '0))
    else $error("new event while results pending");

  assert property (@(posedge clk) disable iff (rst)
    release_lanes |-> !adv)
    else $error("lanes released during transfer");

endmodule

[rtl/core/fadc_pulse_peak_integral.sv]
// Top level: event position, configuration, four channel lanes and merge stage.
// Takes one input transfer per cycle; byte lanes are processed in parallel.
// Closing an event starts the 24-step pedestal divider, multiply and subtract; results
// then leave through the output register one per cycle while out_ready is high.
// Input stalls only if an event closes before the previous results have left.
// Synchronous reset restores the configuration defaults and clears all accumulators.
module fadc_pulse_peak_integral
  import fppi_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [BYTE_W-1:0]         byte_lane0,
  input  logic [BYTE_W-1:0]         byte_lane1,
  input  logic [BYTE_W-1:0]         byte_lane2,
  input  logic [BYTE_W-1:0]         byte_lane3,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CH_W-1:0]           channel,
  output logic [PEAK_W-1:0]         peak_q6,
  output logic signed [INTEG_W-1:0] integral_q6,
  output logic                      last
);

  logic [CNT_W-1:0]  samples_per_event;
  logic [WIN_W-1:0]  pedestal_window;
  logic [MASK_W-1:0] channel_mask;
  logic [POS_W-1:0]  pos;

  logic [CNT_W-1:0]  ns_eff;
  logic [WIN_W-1:0]  win_eff;
  logic [POS_W:0]    len;
  logic [POS_W:0]    pos_inc;
  logic [POS_W:0]    consumed;
  logic [POS_W-1:0]  off;
  logic              in_body;
  logic              close_now;
  logic [CNT_W-1:0]  count;
  logic              all_idle;
  logic              any_idle;
  logic              release_lanes;
  fppi_ctl_t         ctl;
  fppi_res_t         res [NUM_CHANNELS];
  logic [BYTE_W-1:0] lane_bytes [NUM_CHANNELS];

  assign lane_bytes[0] = byte_lane0;
  assign lane_bytes[1] = byte_lane1;
  assign lane_bytes[2] = byte_lane2;
  assign lane_bytes[3] = byte_lane3;

  always_comb begin
    if (samples_per_event == '0) begin
      ns_eff = CNT_W'(1);
    end else if (samples_per_event > CNT_W'(MAX_SAMPLES)) begin
      ns_eff = CNT_W'(MAX_SAMPLES);
    end else begin
      ns_eff = samples_per_event;
    end
    if (pedestal_window == '0) begin
      win_eff = WIN_W'(1);
    end else if (pedestal_window > WIN_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = pedestal_window;
    end
  end

  assign len       = (POS_W+1)'(HEADER_BYTES) + {1'b0, ns_eff, 1'b0};
  assign pos_inc   = {1'b0, pos} + (POS_W+1)'(1);
  assign close_now = pos_inc >= len;
  assign in_body   = pos >= POS_W'(HEADER_BYTES);
  assign off       = pos - POS_W'(HEADER_BYTES);
  assign consumed  = pos_inc - (POS_W+1)'(HEADER_BYTES);
  assign count     = consumed[CNT_W:1];

  always_comb begin
    all_idle = 1'b1;
    any_idle = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      all_idle = all_idle & res[i].idle;
      any_idle = any_idle | res[i].idle;
    end
  end

  assign in_ready  = all_idle || !close_now;
  assign cfg_ready = 1'b1;

  always_comb begin
    ctl.step      = in_valid && in_ready;
    ctl.take_low  = in_body && !off[0];
    ctl.take_high = in_body && off[0];
    ctl.in_window = off[POS_W-1:1] < {3'b0, win_eff};
    ctl.close     = close_now;
    ctl.pedn      = (count < {3'b0, win_eff}) ? count[WIN_W-1:0] : win_eff;
    ctl.count     = count;
    ctl.mask      = channel_mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_event <= CNT_W'(MAX_SAMPLES);
      pedestal_window   <= WIN_W'(WINDOW_RESET);
      channel_mask      <= MASK_W'(15);
      pos               <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLES: samples_per_event <= cfg_data;
          REG_WINDOW:  pedestal_window   <= cfg_data[WIN_W-1:0];
          REG_MASK:    channel_mask      <= cfg_data[MASK_W-1:0];
          default: begin
          end
        endcase
      end
      if (ctl.step) begin
        pos <= close_now ? '0 : pos_inc[POS_W-1:0];
      end
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_lane
    fppi_lane u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .byte_in       (lane_bytes[g]),
      .release_lanes (release_lanes),
      .res           (res[g])
    );
  end

  fppi_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .res           (res),
    .release_lanes (release_lanes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel       (channel),
    .peak_q6       (peak_q6),
    .integral_q6   (integral_q6),
    .last          (last)
  );

  assert property (@(posedge clk) disable iff (rst)
    any_idle |-> all_idle)
    else $error("lanes out of step");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.step && close_now) |=> (pos == '0))
    else $error("position not cleared at event end");

  assert property (@(posedge clk) disable iff (rst)
    (ctl.step && close_now) |-> (count != '0))
    else $error("event closed with no samples");

endmodule
